[hw/rtl/biq_pkg.sv]
// Shared types and constants of the biquad filter: coefficient indexes and datapath commands.
package biq_pkg;

    localparam int NUM_COEF  = 5;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_sel;

    typedef enum logic [1:0] {
        MUL_IN,
        MUL_X,
        MUL_Y
    } t_mul_src;

    typedef enum logic [1:0] {
        ADD_P1,
        ADD_P2,
        ADD_ACC,
        ADD_ZERO
    } t_add_src;

    typedef enum logic [1:0] {
        DST_ACC,
        DST_P1,
        DST_P2
    } t_add_dst;

    typedef struct packed {
        logic      mul_en;
        t_mul_src  mul_src;
        t_coef_sel coef_sel;
        logic      shape_en;
        logic      add_en;
        logic      add_sub;
        t_add_src  add_src;
        t_add_dst  add_dst;
        logic      y_en;
        logic      out_load;
    } t_dp_cmd;

endpackage

[hw/rtl/biq_datapath.sv]
// Datapath of the biquad filter: coefficients, shared multiplier, term shaping, saturating adder.
module biq_datapath
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 32,
    parameter int STATE_WIDTH  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [COEF_WIDTH-1:0]          i_cfg_data,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int CW  = COEF_WIDTH;
    localparam int ST  = STATE_WIDTH;
    localparam int PW  = SW + CW;
    localparam int EW  = (PW > 64) ? PW : 64;
    localparam int QW  = (ST > SW) ? ST : SW;
    localparam int SF  = (ST - SW - 2 > 0) ? (ST - SW - 2) : 0;
    localparam int SHR = (CW - 2) - SF;
    localparam int RSH = (SHR > 0) ? SHR : 0;
    localparam int LSH = (SHR < 0) ? -SHR : 0;

    localparam logic signed [EW-1:0] P_MAX  = {{(EW-63){1'b0}}, {63{1'b1}}};
    localparam logic signed [EW-1:0] P_NMAX = {{(EW-63){1'b1}}, {62{1'b0}}, 1'b1};
    localparam logic signed [63:0]   I64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0]   I64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0]   SHL_LIM  = I64_MAX >>> LSH;
    localparam logic signed [63:0]   SHL_NLIM = -SHL_LIM;
    localparam logic signed [63:0]   ST_MAX = {{(64-ST+1){1'b0}}, {(ST-1){1'b1}}};
    localparam logic signed [63:0]   ST_MIN = {{(64-ST+1){1'b1}}, {(ST-1){1'b0}}};
    localparam logic signed [QW-1:0] Y_MAX  = {{(QW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [QW-1:0] Y_MIN  = {{(QW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic [CW-1:0]        B0_RESET = {2'b01, {(CW-2){1'b0}}};

    logic        [CW-1:0] r_coef [NUM_COEF];
    logic signed [SW-1:0] r_x;
    logic signed [SW-1:0] r_y;
    logic signed [SW-1:0] r_out;
    logic signed [PW-1:0] r_prod;
    logic signed [ST-1:0] r_term;
    logic signed [ST-1:0] r_acc;
    logic signed [ST-1:0] r_p1;
    logic signed [ST-1:0] r_p2;

    logic signed [SW-1:0] w_mul_a;
    logic signed [CW-1:0] w_mul_c;
    logic signed [PW-1:0] n_prod;
    logic signed [EW-1:0] w_pext;
    logic signed [EW-1:0] w_psat;
    logic signed [63:0]   w_p64;
    logic signed [63:0]   w_pshift;
    logic signed [63:0]   w_pclamp;
    logic signed [ST-1:0] n_term;
    logic signed [ST-1:0] w_add_a;
    logic signed [ST:0]   w_sum;
    logic signed [ST-1:0] w_sum_sat;
    logic signed [ST-1:0] w_acc_sh;
    logic signed [QW-1:0] w_acc_q;
    logic signed [SW-1:0] n_y;

    always_comb begin
        case (i_cmd.mul_src)
            MUL_IN:  w_mul_a = i_sample_in;
            MUL_X:   w_mul_a = r_x;
            MUL_Y:   w_mul_a = r_y;
            default: w_mul_a = r_x;
        endcase
        w_mul_c = r_coef[i_cmd.coef_sel];
        n_prod  = $signed({{CW{w_mul_a[SW-1]}}, w_mul_a})
                * $signed({{SW{w_mul_c[CW-1]}}, w_mul_c});
    end

    always_comb begin
        w_pext = EW'(r_prod);
        if (w_pext > P_MAX) begin
            w_psat = P_MAX;
        end else if (w_pext < P_NMAX) begin
            w_psat = P_NMAX;
        end else begin
            w_psat = w_pext;
        end
        w_p64 = w_psat[63:0];
        if (LSH == 0) begin
            w_pshift = w_p64 >>> RSH;
        end else if (w_p64 > SHL_LIM) begin
            w_pshift = I64_MAX;
        end else if (w_p64 < SHL_NLIM) begin
            w_pshift = I64_MIN;
        end else begin
            w_pshift = w_p64 <<< LSH;
        end
        if (w_pshift > ST_MAX) begin
            w_pclamp = ST_MAX;
        end else if (w_pshift < ST_MIN) begin
            w_pclamp = ST_MIN;
        end else begin
            w_pclamp = w_pshift;
        end
        n_term = w_pclamp[ST-1:0];
    end

    always_comb begin
        case (i_cmd.add_src)
            ADD_P1:   w_add_a = r_p1;
            ADD_P2:   w_add_a = r_p2;
            ADD_ACC:  w_add_a = r_acc;
            ADD_ZERO: w_add_a = '0;
            default:  w_add_a = '0;
        endcase
        if (i_cmd.add_sub) begin
            w_sum = {w_add_a[ST-1], w_add_a} - {r_term[ST-1], r_term};
        end else begin
            w_sum = {w_add_a[ST-1], w_add_a} + {r_term[ST-1], r_term};
        end
        if (w_sum[ST] != w_sum[ST-1]) begin
            w_sum_sat = w_sum[ST] ? {1'b1, {(ST-1){1'b0}}} : {1'b0, {(ST-1){1'b1}}};
        end else begin
            w_sum_sat = w_sum[ST-1:0];
        end
    end

    always_comb begin
        w_acc_sh = r_acc >>> SF;
        w_acc_q  = QW'(w_acc_sh);
        if (w_acc_q > Y_MAX) begin
            n_y = Y_MAX[SW-1:0];
        end else if (w_acc_q < Y_MIN) begin
            n_y = Y_MIN[SW-1:0];
        end else begin
            n_y = w_acc_q[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[COEF_B0] <= B0_RESET;
            r_coef[COEF_B1] <= '0;
            r_coef[COEF_B2] <= '0;
            r_coef[COEF_A1] <= '0;
            r_coef[COEF_A2] <= '0;
        end else if (i_cfg_wr_en && (i_cfg_index < CFG_IDX_W'(NUM_COEF))) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= '0;
            r_p2 <= '0;
        end else if (i_cmd.add_en) begin
            case (i_cmd.add_dst)
                DST_P1:  r_p1 <= w_sum_sat;
                DST_P2:  r_p2 <= w_sum_sat;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.mul_en && (i_cmd.mul_src == MUL_IN)) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.shape_en) begin
            r_term <= n_term;
        end
        if (i_cmd.add_en && (i_cmd.add_dst == DST_ACC)) begin
            r_acc <= w_sum_sat;
        end
        if (i_cmd.y_en) begin
            r_y <= n_y;
        end
        if (i_cmd.out_load) begin
            r_out <= r_y;
        end
    end

    assign o_sample_out = r_out;

endmodule

[hw/rtl/biq_ctrl.sv]
// Sequencer of the biquad filter: schedules the shared multiplier and adder, owns the handshakes.
module biq_ctrl
    import biq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHAPE_B0,
        S_ACC_B0,
        S_ACC_B1,
        S_LOAD_B2,
        S_SHAPE_A1,
        S_ACC_A1,
        S_ACC_A2
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '{mul_en: 1'b0, mul_src: MUL_X, coef_sel: COEF_B0, shape_en: 1'b0,
                  add_en: 1'b0, add_sub: 1'b0, add_src: ADD_ZERO, add_dst: DST_ACC,
                  y_en: 1'b0, out_load: 1'b0};
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.mul_src  = MUL_IN;
                    o_cmd.coef_sel = COEF_B0;
                    n_state        = S_SHAPE_B0;
                end
            end
            S_SHAPE_B0: begin
                o_cmd.shape_en = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_src  = MUL_X;
                o_cmd.coef_sel = COEF_B1;
                n_state        = S_ACC_B0;
            end
            S_ACC_B0: begin
                o_cmd.add_en   = 1'b1;
                o_cmd.add_src  = ADD_P1;
                o_cmd.add_dst  = DST_ACC;
                o_cmd.shape_en = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_src  = MUL_X;
                o_cmd.coef_sel = COEF_B2;
                n_state        = S_ACC_B1;
            end
            S_ACC_B1: begin
                o_cmd.y_en     = 1'b1;
                o_cmd.add_en   = 1'b1;
                o_cmd.add_src  = ADD_P2;
                o_cmd.add_dst  = DST_ACC;
                o_cmd.shape_en = 1'b1;
                n_state        = S_LOAD_B2;
            end
            S_LOAD_B2: begin
                o_cmd.add_en   = 1'b1;
                o_cmd.add_src  = ADD_ZERO;
                o_cmd.add_dst  = DST_P2;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_src  = MUL_Y;
                o_cmd.coef_sel = COEF_A1;
                n_state        = S_SHAPE_A1;
            end
            S_SHAPE_A1: begin
                o_cmd.shape_en = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_src  = MUL_Y;
                o_cmd.coef_sel = COEF_A2;
                n_state        = S_ACC_A1;
            end
            S_ACC_A1: begin
                o_cmd.add_en   = 1'b1;
                o_cmd.add_sub  = 1'b1;
                o_cmd.add_src  = ADD_ACC;
                o_cmd.add_dst  = DST_P1;
                o_cmd.shape_en = 1'b1;
                n_state        = S_ACC_A2;
            end
            S_ACC_A2: begin
                if (w_out_free) begin
                    o_cmd.add_en   = 1'b1;
                    o_cmd.add_sub  = 1'b1;
                    o_cmd.add_src  = ADD_P2;
                    o_cmd.add_dst  = DST_P2;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[hw/rtl/biquad_iir_filter.sv]
// Top level of the biquad IIR filter: one second-order section in transposed direct form II.
//
// Input channel: i_in_valid / o_in_ready carry one signed sample (i_sample_in) per beat.
// Output channel: o_out_valid / i_out_ready carry one filtered sample (o_sample_out).
// Configuration: i_cfg_wr_en writes i_cfg_data into coefficient i_cfg_index
//   (0 b0, 1 b1, 2 b2, 3 a1, 4 a2, signed Q2.30 by default); other indexes are ignored.
//   Write only while no sample is in flight.
// After the input beat is taken the sequencer steps through S_SHAPE_B0, S_ACC_B0, S_ACC_B1,
//   S_LOAD_B2, S_SHAPE_A1, S_ACC_A1 and S_ACC_A2, and S_ACC_A2 loads the output register. A new
//   sample is taken only in S_IDLE, since the single shared multiplier forms the five coefficient
//   products one after another, and the single saturating adder follows it.
// The output register holds one result; the next sample is taken and worked on while
//   it waits. If the receiver still stalls when that sample finishes, the block holds
//   in its last step and takes no new beat until the output register frees.
// Reset (synchronous, active low) clears both partial sums and the output valid,
//   sets b0 to 1.0 and the other coefficients to zero; the block is ready at once.
module biquad_iir_filter
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 32,
    parameter int STATE_WIDTH  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input  logic                           i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [COEF_WIDTH-1:0]          i_cfg_data
);

    t_dp_cmd w_cmd;

    biq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    biq_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_sample_in  (i_sample_in),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_sample_out (o_sample_out)
    );

endmodule

[tb/testbench.sv]
// Self-checking testbench for biquad_iir_filter against a fixed-point predictor.
import biq_pkg::*;

class filter_scoreboard;
    localparam int SAMPLE_W = 16;
    localparam int STATE_W  = 48;
    localparam int FRAC     = 30;

    logic signed [31:0]         taps [NUM_COEF];
    longint                     z1;
    longint                     z2;
    logic signed [SAMPLE_W-1:0] outputs_due [$];
    int                         mismatches;
    int                         results_seen;

    function new();
        taps[COEF_B0] = 32'sh4000_0000;
        taps[COEF_B1] = '0;
        taps[COEF_B2] = '0;
        taps[COEF_A1] = '0;
        taps[COEF_A2] = '0;
        z1 = 0;
        z2 = 0;
        mismatches = 0;
        results_seen = 0;
    endfunction

    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        if (idx < NUM_COEF) taps[idx] = value;
    endfunction

    function longint saturate(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] x);
        longint xs, ys, acc, n1, n2;
        xs = x;
        acc = saturate(z1 + xs * taps[COEF_B0], STATE_W);
        ys = saturate(acc >>> FRAC, SAMPLE_W);
        n1 = saturate(z2 + xs * taps[COEF_B1], STATE_W);
        n1 = saturate(n1 - ys * taps[COEF_A1], STATE_W);
        n2 = saturate(xs * taps[COEF_B2] - ys * taps[COEF_A2], STATE_W);
        z1 = n1;
        z2 = n2;
        outputs_due.push_back(ys[SAMPLE_W-1:0]);
    endfunction

    function void flag(string msg);
        if (mismatches < 10) $display("%s", msg);
        mismatches++;
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] got);
        logic signed [SAMPLE_W-1:0] want;
        results_seen++;
        if (outputs_due.size() == 0) begin
            flag($sformatf("output beat %0d: none outstanding, got %0d", results_seen, got));
            return;
        end
        want = outputs_due.pop_front();
        if (got !== want)
            flag($sformatf("output beat %0d: expected %0d got %0d", results_seen, want, got));
    endfunction
endclass

module testbench;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam logic [COEF_W-1:0] Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] Q_MIN       = 32'h8000_0000;
    localparam logic [COEF_W-1:0] Q_ONE       = 32'h4000_0000;
    localparam logic [COEF_W-1:0] Q_MINUS_ONE = 32'hC000_0000;

    typedef enum {RX_OPEN, RX_JITTER, RX_LONG} t_rx_style;
    typedef enum {CS_EXTREME, CS_RANDOM, CS_GENTLE} t_coef_style;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample_in  = '0;
    logic                       o_out_valid;
    logic                       i_out_ready  = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       i_cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index  = '0;
    logic [COEF_W-1:0]          i_cfg_data   = '0;

    filter_scoreboard           sb;
    t_rx_style                  rx_style     = RX_OPEN;
    int                         rx_hold      = 0;
    int                         burst_left   = 0;
    int                         gap_max      = 0;
    logic signed [SAMPLE_W-1:0] last_sample  = '0;
    logic [COEF_W-1:0]          tap_plan [NUM_COEF];

    biquad_iir_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("biquad_iir_filter regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_sample(i_sample_in);
            if (o_out_valid && i_out_ready) sb.check_sample(o_sample_out);
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            case (rx_style)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_JITTER: i_out_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    i_out_ready <= ~i_out_ready;
                    rx_hold <= i_out_ready ? $urandom_range(0, 25) : $urandom_range(0, 12);
                end
            endcase
        end
    end

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_coef(idx, value);
    endtask

    task automatic program_taps(input bit [NUM_COEF-1:0] mask, input bit poke_spare);
        for (int k = 0; k < NUM_COEF; k++)
            if (mask[k]) write_coef(k[CFG_IDX_W-1:0], tap_plan[k]);
        if (poke_spare)
            for (int k = NUM_COEF; k < 2 ** CFG_IDX_W; k++)
                write_coef(k[CFG_IDX_W-1:0], $urandom());
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.outputs_due.size() != 0);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            4, 5: begin
                v = int'($urandom_range(0, 512)) - 256;
                return v[SAMPLE_W-1:0];
            end
            6: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return '0;
                    default: return -16'sd1;
                endcase
            end
            7, 8: return last_sample;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(t_coef_style style, int k);
        int v;
        case (style)
            CS_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return Q_ONE;
                    default: return Q_MINUS_ONE;
                endcase
            end
            CS_GENTLE: begin
                // keep the poles on or inside the unit circle: 0 <= a2 < 1, |a1| <= 1
                if (k == COEF_A2)
                    v = int'($urandom_range(0, 32'h3800_0000));
                else if (k == COEF_A1)
                    v = int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
                else
                    v = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
                return v;
            end
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] probes [7] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001,
                                            16'hFFFF, 16'h5555, 16'hAAAA};
        t_coef_style style;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rx_style = RX_JITTER;
        foreach (probes[k]) send_sample(probes[k]);
        drain();

        // drive the partial sums into positive saturation
        tap_plan[COEF_B0] = Q_MAX;
        tap_plan[COEF_B1] = Q_MAX;
        tap_plan[COEF_B2] = Q_MAX;
        tap_plan[COEF_A1] = Q_MIN;
        tap_plan[COEF_A2] = Q_MIN;
        program_taps('1, 1'b1);
        repeat (3) send_sample(16'sh7FFF);
        repeat (3) send_sample(16'sh8000);
        drain();

        // and into negative saturation
        tap_plan[COEF_B0] = Q_MIN;
        tap_plan[COEF_B1] = Q_MIN;
        tap_plan[COEF_B2] = Q_MIN;
        program_taps('1, 1'b0);
        repeat (3) send_sample(16'sh7FFF);
        repeat (2) send_sample(16'sh8000);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            style = t_coef_style'($urandom_range(0, 2));
            for (int k = 0; k < NUM_COEF; k++) tap_plan[k] = pick_coef(style, k);
            program_taps(NUM_COEF'($urandom()), 1'($urandom_range(0, 1)));
            rx_style = t_rx_style'(phase % 3);
            gap_max = (phase % 4 == 0) ? 0 : $urandom_range(2, 12);
            repeat (160) begin
                last_sample = pick_sample();
                send_sample(last_sample);
            end
            drain();
        end

        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outputs_due.size() == 0)
            $display("biquad_iir_filter regression: pass");
        else
            $display("biquad_iir_filter regression: fail");
        $finish;
    end
endmodule
